@@ hdl/dhps_pkg.sv @@
// Package for the double hash pointer set: shared types, codes and hash helpers.
// Used by dhps_front, dhps_back, the top level and the bench; depends on nothing.
package dhps_pkg;

    localparam int          CAPACITY   = 2048;
    localparam logic [31:0] MIX_MUL    = 32'h045d9f3b;
    localparam logic [31:0] H2_SALT    = 32'h0002aaaa;
    localparam logic [11:0] SIZE_RESET = 12'd53;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } status_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MIX1,
        BK_MIX2,
        BK_MIX3,
        BK_MOD,
        BK_ADDR,
        BK_READ,
        BK_CHECK,
        BK_DONE,
        BK_CLEAR
    } bk_state_t;

    // Item as queued between the front and back parts
    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic [31:0] folded;
    } item_t;

    // Result handed back from the back part
    typedef struct packed {
        status_t     status;
        logic [10:0] slot;
        logic        load_high;
    } result_t;

    function automatic logic [31:0] xs16(input logic [31:0] x);
        xs16 = (x >> 16) ^ x;
    endfunction

endpackage

@@ hdl/dhps_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module dhps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/dhps_front.sv @@
// Front part: accepts items, folds the key and holds them in a two-entry queue.
// Depends on dhps_pkg.
module dhps_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_op,
    input  logic [63:0]     s_key,
    output logic            q_valid,
    input  logic            q_pop,
    output dhps_pkg::item_t q_item
);

    dhps_pkg::item_t ent_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];

    // Queue pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    // Queue payload, key folded on entry
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg].op     <= dhps_pkg::op_t'(s_op);
            ent_reg[wr_ptr_reg].key    <= s_key;
            ent_reg[wr_ptr_reg].folded <= s_key[31:0] ^ s_key[63:32];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready) else $error("accept into full queue");
`endif

endmodule

@@ hdl/dhps_divmod.sv @@
// Serial remainder unit: 32-bit dividend by 12-bit divisor, one bit per cycle.
// Depends on nothing.
module dhps_divmod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [11:0] divisor,
    output logic        busy,
    output logic [11:0] rem
);

    logic [31:0] num_reg;
    logic [12:0] rem_reg;
    logic [11:0] div_reg;
    logic [5:0]  cnt_reg;
    logic [12:0] shifted;

    assign busy    = (cnt_reg != 6'd0);
    assign rem     = rem_reg[11:0];
    assign shifted = {rem_reg[11:0], num_reg[31]};

    // Restoring remainder, MSB first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= 13'd0;
            div_reg <= divisor;
        end else if (busy) begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= (shifted >= {1'b0, div_reg}) ? shifted - {1'b0, div_reg} : shifted;
        end
    end

endmodule

@@ hdl/dhps_back.sv @@
// Back part: hashes, reduces and walks the probe sequence over the table.
// Depends on dhps_pkg, dhps_divmod, dhps_ram.
module dhps_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [11:0]       cfg_size,
    input  logic              q_valid,
    output logic              q_pop,
    input  dhps_pkg::item_t   q_item,
    output logic              r_valid,
    input  logic              r_ready,
    output dhps_pkg::result_t r_data
);

    localparam int AW = $clog2(dhps_pkg::CAPACITY);
    localparam int SW = AW + 1;

    dhps_pkg::bk_state_t state_reg, state_next;
    logic [31:0] x1_reg, x2_reg;
    logic [SW-1:0] size_reg;
    logic [SW-1:0] h1_reg, h2_reg, idx_reg, i_reg;
    logic [AW-1:0] clr_reg;
    logic          mod_phase_reg;
    logic [11:0]   cnt_reg;
    dhps_pkg::result_t res_reg;
    logic          res_valid_reg;
    dhps_pkg::item_t cur_reg;

    logic          dv_start, dv_busy;
    logic [31:0]   dv_num;
    logic [11:0]   dv_den, dv_rem;
    logic          occ_we, occ_wd, occ_rd;
    logic          key_we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   key_rd;
    logic [SW-1:0] eff_size;
    logic [SW:0]   idx_sum;
    logic [14:0]   cnt5;
    logic [14:0]   size3;
    logic [11:0]   cnt_after;

    // Clamp configured size to 3..CAPACITY
    always_comb begin
        if (cfg_size < 12'd3) eff_size = SW'(3);
        else if (cfg_size > 12'(dhps_pkg::CAPACITY))
            eff_size = SW'(dhps_pkg::CAPACITY);
        else eff_size = SW'(cfg_size);
    end

    dhps_divmod u_div (
        .aclk, .aresetn, .start(dv_start), .dividend(dv_num), .divisor(dv_den),
        .busy(dv_busy), .rem(dv_rem)
    );

    dhps_ram #(.WIDTH(64), .DEPTH(dhps_pkg::CAPACITY)) u_keys (
        .aclk, .we(key_we), .waddr(waddr), .wdata(cur_reg.key),
        .raddr(raddr), .rdata(key_rd)
    );

    dhps_ram #(.WIDTH(1), .DEPTH(dhps_pkg::CAPACITY)) u_occ (
        .aclk, .we(occ_we), .waddr(waddr), .wdata(occ_wd),
        .raddr(raddr), .rdata(occ_rd)
    );

    assign raddr   = idx_reg[AW-1:0];
    assign idx_sum = {1'b0, idx_reg} + {1'b0, h2_reg};
    assign r_valid = res_valid_reg;
    assign r_data  = res_reg;
    assign cnt_after = (cnt_reg != 12'hfff) ? cnt_reg + 12'd1 : cnt_reg;
    assign size3   = 15'(size_reg) * 15'd3;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= dhps_pkg::BK_CLEAR;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        dv_start   = 1'b0;
        // second reduction: finished hash2 by size-1
        dv_num     = x2_reg;
        dv_den     = 12'(size_reg - SW'(1));
        occ_we     = 1'b0;
        occ_wd     = 1'b1;
        key_we     = 1'b0;
        waddr      = idx_reg[AW-1:0];
        cnt5       = 15'(cnt_reg) * 15'd5;
        unique case (state_reg)
            dhps_pkg::BK_CLEAR: begin
                occ_we = 1'b1;
                occ_wd = 1'b0;
                waddr  = clr_reg;
                if (clr_reg == AW'(dhps_pkg::CAPACITY - 1)) state_next = dhps_pkg::BK_IDLE;
            end
            dhps_pkg::BK_IDLE: begin
                if (q_valid && !res_valid_reg) begin
                    q_pop = 1'b1;
                    state_next = dhps_pkg::BK_MIX1;
                end
            end
            dhps_pkg::BK_MIX1: state_next = dhps_pkg::BK_MIX2;
            dhps_pkg::BK_MIX2: state_next = dhps_pkg::BK_MIX3;
            dhps_pkg::BK_MIX3: begin
                // first reduction: final xor-shift of hash1, by size
                dv_start   = 1'b1;
                dv_num     = dhps_pkg::xs16(x1_reg);
                dv_den     = 12'(size_reg);
                state_next = dhps_pkg::BK_MOD;
            end
            dhps_pkg::BK_MOD: begin
                if (!dv_busy && !mod_phase_reg) begin
                    // x2 reduction starts once h1 is in
                    state_next = dhps_pkg::BK_MOD;
                end else if (!dv_busy) begin
                    state_next = dhps_pkg::BK_ADDR;
                end
            end
            dhps_pkg::BK_ADDR: state_next = dhps_pkg::BK_READ;
            dhps_pkg::BK_READ: state_next = dhps_pkg::BK_CHECK;
            dhps_pkg::BK_CHECK: begin
                if (!occ_rd) begin
                    if (cur_reg.op == dhps_pkg::OP_INSERT) begin
                        occ_we = 1'b1;
                        key_we = 1'b1;
                        cnt5   = 15'(cnt_after) * 15'd5;
                    end
                    state_next = dhps_pkg::BK_DONE;
                end else if (key_rd == cur_reg.key || i_reg == size_reg - SW'(1)) begin
                    state_next = dhps_pkg::BK_DONE;
                end else begin
                    state_next = dhps_pkg::BK_READ;
                end
            end
            dhps_pkg::BK_DONE: begin
                if (!res_valid_reg) state_next = dhps_pkg::BK_IDLE;
            end
            default: state_next = dhps_pkg::BK_IDLE;
        endcase
        if (state_reg == dhps_pkg::BK_MOD && !dv_busy && !mod_phase_reg) dv_start = 1'b1;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            cnt_reg       <= 12'd0;
            res_valid_reg <= 1'b0;
            mod_phase_reg <= 1'b0;
        end else begin
            if (state_reg == dhps_pkg::BK_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (r_valid && r_ready) res_valid_reg <= 1'b0;
            if (state_reg == dhps_pkg::BK_MIX3) mod_phase_reg <= 1'b0;
            if (state_reg == dhps_pkg::BK_MOD && !dv_busy && !mod_phase_reg)
                mod_phase_reg <= 1'b1;
            if (state_reg == dhps_pkg::BK_CHECK && !occ_rd &&
                cur_reg.op == dhps_pkg::OP_INSERT)
                cnt_reg <= cnt_after;
            if (state_reg == dhps_pkg::BK_CHECK && state_next == dhps_pkg::BK_DONE)
                res_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dhps_pkg::BK_IDLE: begin
                cur_reg  <= q_item;
                size_reg <= eff_size;
                x1_reg   <= q_item.folded;
                x2_reg   <= q_item.folded ^ dhps_pkg::H2_SALT;
            end
            dhps_pkg::BK_MIX1, dhps_pkg::BK_MIX2: begin
                x1_reg <= dhps_pkg::xs16(x1_reg) * dhps_pkg::MIX_MUL;
                x2_reg <= dhps_pkg::xs16(x2_reg) * dhps_pkg::MIX_MUL;
            end
            dhps_pkg::BK_MIX3: begin
                x1_reg <= dhps_pkg::xs16(x1_reg);
                x2_reg <= dhps_pkg::xs16(x2_reg);
            end
            dhps_pkg::BK_MOD: begin
                if (!dv_busy && !mod_phase_reg) h1_reg <= SW'(dv_rem);
                if (!dv_busy && mod_phase_reg) h2_reg <= SW'(dv_rem) + SW'(1);
            end
            dhps_pkg::BK_ADDR: begin
                idx_reg <= h1_reg;
                i_reg   <= '0;
            end
            dhps_pkg::BK_CHECK: begin
                if (!occ_rd) begin
                    res_reg.status <= (cur_reg.op == dhps_pkg::OP_INSERT) ?
                        dhps_pkg::ST_INSERTED : dhps_pkg::ST_MISSING;
                    res_reg.slot   <= (cur_reg.op == dhps_pkg::OP_INSERT) ?
                        11'(idx_reg) : 11'd0;
                end else if (key_rd == cur_reg.key) begin
                    res_reg.status <= (cur_reg.op == dhps_pkg::OP_INSERT) ?
                        dhps_pkg::ST_PRESENT : dhps_pkg::ST_FOUND;
                    res_reg.slot   <= 11'(idx_reg);
                end else begin
                    res_reg.status <= (cur_reg.op == dhps_pkg::OP_INSERT) ?
                        dhps_pkg::ST_FULL : dhps_pkg::ST_MISSING;
                    res_reg.slot   <= 11'd0;
                end
                res_reg.load_high <= (cnt5 > size3);
                i_reg   <= i_reg + SW'(1);
                idx_reg <= (idx_sum >= {1'b0, size_reg}) ?
                    SW'(idx_sum - {1'b0, size_reg}) : SW'(idx_sum);
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == dhps_pkg::BK_IDLE && !res_valid_reg))
        else $error("pop outside idle");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dhps_pkg::BK_CHECK) |-> (idx_reg < size_reg))
        else $error("probe index out of range");
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_valid && !r_ready) |=> (r_valid && $stable(r_data)))
        else $error("result changed while stalled");
`endif

endmodule

@@ hdl/double_hash_pointer_set_unit.sv @@
// Top level of the double hash pointer set; configuration register and wiring.
// Depends on dhps_pkg, dhps_front, dhps_back.
//
//  channel  | direction | fields
//  s_axis   | in        | tuser: op[0]; tdata: key[63:0]
//  m_axis   | out       | tuser: status[2:0]; tdata: slot[10:0], load_high[11]
//  cfg      | in        | active_size[11:0]
//
// Per item the back part runs mixing states MIX1 to MIX3, two serial remainders on
// one bit-per-cycle unit, and a RAM read per probe. After reset every entry of the
// occupancy RAM is cleared before items start.
// A two-entry queue lets the input keep taking items while results stall.
module double_hash_pointer_set_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[63:0]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // slot[10:0], load_high[11]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    logic [11:0] size_reg;
    logic            q_valid, q_pop;
    dhps_pkg::item_t q_item;
    dhps_pkg::result_t r_data;

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) size_reg <= dhps_pkg::SIZE_RESET;
        else if (cfg_we) size_reg <= cfg_wdata;
    end

    dhps_front u_front (
        .aclk, .aresetn, .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_op(s_axis_tuser), .s_key(s_axis_tdata),
        .q_valid, .q_pop, .q_item
    );

    dhps_back u_back (
        .aclk, .aresetn, .cfg_size(size_reg), .q_valid, .q_pop, .q_item,
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data
    );

    assign m_axis_tdata = {4'b0000, r_data.load_high, r_data.slot};
    assign m_axis_tuser = r_data.status;

endmodule

@@ test/double_hash_pointer_set_unit_test.sv @@
// Self-checking bench for double_hash_pointer_set_unit: directed table, then random
// insert/lookup traffic checked against an internal hash-set predictor.
// Depends on dhps_pkg and the block under hdl.
module double_hash_pointer_set_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = dhps_pkg::CAPACITY;
    localparam int IDLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // key[63:0]
    logic        s_axis_tuser = 1'b0; // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // slot[10:0], load_high[11]
    logic [2:0]  m_axis_tuser;        // status[2:0]
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    double_hash_pointer_set_unit u_top (.*);

    // Predictor state
    logic [63:0] set_keys [CAP];
    bit          set_used [CAP];
    int unsigned set_count;
    logic [11:0] set_size_reg;
    dhps_pkg::result_t pending_results [$];

    int errors = 0;
    int n_sent = 0, n_recv = 0, n_ins = 0, n_look = 0, n_full = 0;
    int idle_cycles = 0;
    bit sending_done = 0;

    // Directed table: expected status typed in where obvious, else predicted
    typedef struct {
        dhps_pkg::op_t     op;
        logic [63:0]       key;
        bit                has_exp;
        dhps_pkg::status_t exp_status;
    } dir_row_t;

    function automatic logic [31:0] mix_word(input logic [31:0] x);
        logic [31:0] y;
        y = ((x >> 16) ^ x) * dhps_pkg::MIX_MUL;
        y = ((y >> 16) ^ y) * dhps_pkg::MIX_MUL;
        return (y >> 16) ^ y;
    endfunction

    function automatic dhps_pkg::result_t predict_set_op(input dhps_pkg::op_t op,
                                                         input logic [63:0] key);
        dhps_pkg::result_t r;
        int unsigned sz, h1, h2, idx;
        logic [31:0] folded;
        sz = set_size_reg;
        if (sz < 3) sz = 3;
        if (sz > CAP) sz = CAP;
        folded = key[31:0] ^ key[63:32];
        h1 = mix_word(folded) % sz;
        h2 = (mix_word(folded ^ dhps_pkg::H2_SALT) % (sz - 1)) + 1;
        r.status = (op == dhps_pkg::OP_INSERT) ? dhps_pkg::ST_FULL : dhps_pkg::ST_MISSING;
        r.slot = '0;
        for (int i = 0; i < sz; i++) begin
            idx = (h1 + longint'(i) * h2) % sz;
            if (!set_used[idx]) begin
                if (op == dhps_pkg::OP_INSERT) begin
                    set_used[idx] = 1;
                    set_keys[idx] = key;
                    if (set_count < 4095) set_count++;
                    r.status = dhps_pkg::ST_INSERTED;
                    r.slot = 11'(idx);
                end
                break;
            end
            if (set_keys[idx] == key) begin
                r.status = (op == dhps_pkg::OP_INSERT) ? dhps_pkg::ST_PRESENT :
                                                         dhps_pkg::ST_FOUND;
                r.slot = 11'(idx);
                break;
            end
        end
        r.load_high = (set_count * 5 > sz * 3);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch #%0d %s: got %0d want %0d (t=%0t)", n_recv, what, got, want,
                 $realtime);
        errors++;
    endtask

    // Send one transaction, with a random gap in front
    task automatic send_item(input dhps_pkg::op_t op, input logic [63:0] key,
                             input bit has_exp, input dhps_pkg::status_t exp_status);
        dhps_pkg::result_t r;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata <= key;
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        r = predict_set_op(op, key);
        if (has_exp && r.status != exp_status)
            report_mismatch("table expectation vs predictor", r.status, exp_status);
        pending_results.push_back(r);
        n_sent++;
        if (op == dhps_pkg::OP_INSERT) n_ins++; else n_look++;
        if (r.status == dhps_pkg::ST_FULL) n_full++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_size(input logic [11:0] value);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        set_size_reg = value;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Result side: random stalls, field checks
    always @(posedge aclk) begin
        dhps_pkg::result_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = dhps_pkg::status_t'(m_axis_tuser);
                got.slot      = m_axis_tdata[10:0];
                got.load_high = m_axis_tdata[11];
                n_recv++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result transaction", m_axis_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
                    if (got.load_high != want.load_high)
                        report_mismatch("load_high", got.load_high, want.load_high);
                end
            end
            if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_rows [$];
        logic [63:0] known [$];
        logic [11:0] sizes [6];
        logic [63:0] k;
        dhps_pkg::op_t op;
        int unsigned sz_used;

        foreach (set_used[i]) begin
            set_used[i] = 0;
            set_keys[i] = '0;
        end
        set_count = 0;
        set_size_reg = dhps_pkg::SIZE_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        m_axis_tready <= 1'b1;

        // Directed part at reset size
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, 64'h0, 1, dhps_pkg::ST_MISSING});
        dir_rows.push_back('{dhps_pkg::OP_INSERT, 64'h0, 1, dhps_pkg::ST_INSERTED});
        dir_rows.push_back('{dhps_pkg::OP_INSERT, 64'h0, 1, dhps_pkg::ST_PRESENT});
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, 64'h0, 1, dhps_pkg::ST_FOUND});
        // all-ones folds to zero like key 0: same probe sequence
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, '1, 1, dhps_pkg::ST_MISSING});
        dir_rows.push_back('{dhps_pkg::OP_INSERT, '1, 1, dhps_pkg::ST_INSERTED});
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, '1, 1, dhps_pkg::ST_FOUND});
        // these two share one fold: collide on both hashes
        dir_rows.push_back('{dhps_pkg::OP_INSERT, 64'h0000_0000_FFFF_FFFF, 0,
                             dhps_pkg::ST_INSERTED});
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, 64'hFFFF_FFFF_0000_0000, 0,
                             dhps_pkg::ST_MISSING});
        dir_rows.push_back('{dhps_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 0,
                             dhps_pkg::ST_INSERTED});
        dir_rows.push_back('{dhps_pkg::OP_INSERT, 64'h5555_AAAA_5555_AAAA, 0,
                             dhps_pkg::ST_INSERTED});
        dir_rows.push_back('{dhps_pkg::OP_LOOKUP, 64'h5555_AAAA_5555_AAAA, 1,
                             dhps_pkg::ST_FOUND});
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].has_exp,
                      dir_rows[i].exp_status);

        // Fill tiny table to full: size out of range low, clamped to 3
        drain_results();
        write_size(12'd0);
        for (int i = 0; i < 6; i++)
            send_item(dhps_pkg::OP_INSERT, rand_key(), 0, dhps_pkg::ST_FULL);
        send_item(dhps_pkg::OP_LOOKUP, rand_key(), 0, dhps_pkg::ST_MISSING);
        drain_results();
        write_size(12'd4095); // clamped to capacity
        for (int i = 0; i < 6; i++)
            send_item(dhps_pkg::OP_LOOKUP, rand_key(), 0, dhps_pkg::ST_MISSING);

        // Random phases over several sizes; keys stay across size changes
        sizes = '{12'd5, 12'd2048, 12'd97, 12'd7, 12'd3, 12'd211};
        foreach (sizes[p]) begin
            drain_results();
            write_size(sizes[p]);
            sz_used = (sizes[p] < 3) ? 3 : sizes[p];
            for (int i = 0; i < ((sz_used <= 7) ? 40 : 120); i++) begin
                if (known.size() != 0 && $urandom_range(0, 2) == 0)
                    k = known[$urandom_range(0, known.size() - 1)];
                else begin
                    k = rand_key();
                    known.push_back(k);
                    if (known.size() > 400) void'(known.pop_front());
                end
                op = dhps_pkg::op_t'($urandom_range(0, 1));
                send_item(op, k, 0, dhps_pkg::ST_INSERTED);
                if (i == 10) drain_results();   // sender holds until all results in
            end
        end

        drain_results();
        $display("run: %0d items sent (%0d inserts, %0d lookups), %0d results checked,",
                 n_sent, n_ins, n_look, n_recv);
        $display("     %0d table-full outcomes, sizes 3 to 2048 incl. clamped writes",
                 n_full);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
